>>> rtl/core/source_tokenizer_top_defines.svh
// Assertion macros used by source_tokenizer_top, the only asserting file.
`ifndef SOURCE_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_TOKENIZER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ST_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ST_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

>>> rtl/core/stok_pkg.sv
// ---------------------------------------------------------------------------
// stok_pkg
// Token kinds, error codes, scanner modes, directive strings and the token record type.
// ---------------------------------------------------------------------------
package stok_pkg;

   localparam logic [3:0] M_IDLE = 4'd0, M_IDENT = 4'd1, M_NUM = 4'd2, M_NUMDOT = 4'd3,
      M_FRAC = 4'd4, M_STR = 4'd5, M_ESC = 4'd6, M_LINE = 4'd7, M_BLOCK = 4'd8,
      M_BSTAR = 4'd9, M_DIR = 4'd10, M_OP = 4'd11;

   localparam logic [2:0] E_NONE = 3'd0, E_CHAR = 3'd1, E_STR = 3'd2, E_ESC = 3'd3,
      E_BAR = 3'd4, E_DIR = 3'd5;

   localparam logic [6:0] K_END = 7'd0, K_ERR = 7'd1, K_IDENT = 7'd2, K_INT = 7'd3,
      K_FLOAT = 7'd4, K_STRING = 7'd5, K_ALLOC = 7'd6, K_AND = 7'd7, K_BOOL = 7'd8,
      K_BREAK = 7'd9, K_CATCH = 7'd10, K_CONTINUE = 7'd11, K_ELSE = 7'd12,
      K_FALSE = 7'd13, K_FLOATKW = 7'd14, K_FOR = 7'd15, K_FREE = 7'd16, K_IF = 7'd17,
      K_IN = 7'd18, K_INTKW = 7'd19, K_LIST = 7'd20, K_MAP = 7'd21, K_NULL = 7'd22,
      K_OR = 7'd23, K_RETURN = 7'd24, K_STRINGKW = 7'd25, K_TANTRUM = 7'd26,
      K_THROW = 7'd27, K_TRUE = 7'd28, K_TRY = 7'd29, K_USE = 7'd30, K_VOID = 7'd31,
      K_WHILE = 7'd32, K_LPAREN = 7'd33, K_RPAREN = 7'd34, K_LBRACE = 7'd35,
      K_RBRACE = 7'd36, K_LBRACK = 7'd37, K_RBRACK = 7'd38, K_COMMA = 7'd39,
      K_DOT = 7'd40, K_SEMI = 7'd41, K_COLON = 7'd42, K_PLUS = 7'd43,
      K_PLUSPLUS = 7'd44, K_PLUSEQ = 7'd45, K_MINUS = 7'd46, K_MINUSMINUS = 7'd47,
      K_MINUSEQ = 7'd48, K_STAR = 7'd49, K_STAREQ = 7'd50, K_SLASH = 7'd51,
      K_SLASHEQ = 7'd52, K_PERCENT = 7'd53, K_PERCENTEQ = 7'd54, K_AMP = 7'd55,
      K_BANG = 7'd56, K_BANGEQ = 7'd57, K_EQ = 7'd58, K_EQEQ = 7'd59, K_EQGT = 7'd60,
      K_EQLT = 7'd61, K_LT = 7'd62, K_LTEQ = 7'd63, K_GT = 7'd64, K_GTEQ = 7'd65,
      K_AUTOFREE = 7'd66, K_ALLOWLEAKS = 7'd67;

   localparam int KEYWORD_CHARS = 8;
   localparam int MAX_TOKENS = 3;

   typedef struct packed {
      logic [6:0]  kind;
      logic [2:0]  err;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic        last;
      logic        ends;
   } token_type;

   // Directive text, byte i at [8*i +: 8]; unused bytes zero.
   localparam logic [17*8-1:0] DIR_AUTOFREE = {64'h0, "eerFotua#"};
   localparam logic [17*8-1:0] DIR_LEAKS    = {"skaeLyromeMwolla#"};
   localparam logic [17*8-1:0] DIR_MODE     = {96'h0, "edom#"};

   function automatic logic [7:0] dir_byte(input logic [17*8-1:0] s, input logic [4:0] i);
      logic [7:0] b;
      b = 8'd0;
      for (int k = 0; k < 17; k++)
         if (i == 5'(k)) b = s[8*k +: 8];
      return b;
   endfunction

endpackage

>>> rtl/core/stok_if.sv
// ---------------------------------------------------------------------------
// stok_req_if / stok_rsp_if
// Valid/ready channels for source bytes and tokens.
// ---------------------------------------------------------------------------
interface stok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface stok_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  token_kind;
   logic [2:0]  error_code;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [15:0] line_number;
   logic        last_of_item;
   logic        ends_source;
   modport source (output valid, output token_kind, output error_code, output token_start,
                   output token_length, output line_number, output last_of_item,
                   output ends_source, input ready);
   modport sink   (input valid, input token_kind, input error_code, input token_start,
                   input token_length, input line_number, input last_of_item,
                   input ends_source, output ready);
endinterface

>>> rtl/core/stok_kw.sv
// ---------------------------------------------------------------------------
// stok_kw
// Keyword lookup on the stored first characters of an identifier.
// ---------------------------------------------------------------------------
module stok_kw
   import stok_pkg::*;
(
   input  logic [8*KEYWORD_CHARS-1:0] word,
   input  logic [3:0]                 word_len,
   output logic [6:0]                 kind
);
   function automatic logic hit(input logic [8*KEYWORD_CHARS-1:0] w, input logic [3:0] n,
                                input logic [63:0] txt, input int l);
      logic ok;
      ok = (n == 4'(l));
      for (int i = 0; i < 8; i++)
         if (i < l && w[8*i +: 8] != txt[8*(l-1-i) +: 8]) ok = 1'b0;
      return ok;
   endfunction

   always_comb begin
      kind = K_IDENT;
      if (hit(word, word_len, 64'("alloc"), 5)) kind = K_ALLOC;
      if (hit(word, word_len, 64'("and"), 3)) kind = K_AND;
      if (hit(word, word_len, 64'("bool"), 4)) kind = K_BOOL;
      if (hit(word, word_len, 64'("break"), 5)) kind = K_BREAK;
      if (hit(word, word_len, 64'("catch"), 5)) kind = K_CATCH;
      if (hit(word, word_len, 64'("continue"), 8)) kind = K_CONTINUE;
      if (hit(word, word_len, 64'("else"), 4)) kind = K_ELSE;
      if (hit(word, word_len, 64'("false"), 5)) kind = K_FALSE;
      if (hit(word, word_len, 64'("float"), 5)) kind = K_FLOATKW;
      if (hit(word, word_len, 64'("for"), 3)) kind = K_FOR;
      if (hit(word, word_len, 64'("free"), 4)) kind = K_FREE;
      if (hit(word, word_len, 64'("if"), 2)) kind = K_IF;
      if (hit(word, word_len, 64'("in"), 2)) kind = K_IN;
      if (hit(word, word_len, 64'("int"), 3)) kind = K_INTKW;
      if (hit(word, word_len, 64'("list"), 4)) kind = K_LIST;
      if (hit(word, word_len, 64'("map"), 3)) kind = K_MAP;
      if (hit(word, word_len, 64'("null"), 4)) kind = K_NULL;
      if (hit(word, word_len, 64'("or"), 2)) kind = K_OR;
      if (hit(word, word_len, 64'("return"), 6)) kind = K_RETURN;
      if (hit(word, word_len, 64'("string"), 6)) kind = K_STRINGKW;
      if (hit(word, word_len, 64'("tantrum"), 7)) kind = K_TANTRUM;
      if (hit(word, word_len, 64'("throw"), 5)) kind = K_THROW;
      if (hit(word, word_len, 64'("true"), 4)) kind = K_TRUE;
      if (hit(word, word_len, 64'("try"), 3)) kind = K_TRY;
      if (hit(word, word_len, 64'("use"), 3)) kind = K_USE;
      if (hit(word, word_len, 64'("void"), 4)) kind = K_VOID;
      if (hit(word, word_len, 64'("while"), 5)) kind = K_WHILE;
   end
endmodule

>>> rtl/core/stok_scan.sv
// ---------------------------------------------------------------------------
// stok_scan
// Per-byte scanner: mode update and up to three tokens from one byte.
// ---------------------------------------------------------------------------
module stok_scan
   import stok_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               c,
   output logic                     halted,
   output logic [1:0]               tok_count,
   output token_type [MAX_TOKENS-1:0] toks
);
   logic [3:0]  mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [15:0] line_ff, line_in;
   logic [7:0]  pend_ff, pend_in;
   logic        halt_ff, halt_in;
   logic [3:0]  wlen_ff, wlen_in;
   logic [4:0]  dlen_ff, dlen_in;
   logic [2:0]  dmask_ff, dmask_in;
   logic [8*KEYWORD_CHARS-1:0] word_ff, word_in;
   logic [6:0]  kw_kind;

   stok_kw u_kw (.word(word_ff), .word_len(wlen_ff), .kind(kw_kind));

   function automatic logic alpha(input logic [7:0] x);
      return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
   endfunction
   function automatic logic digit(input logic [7:0] x);
      return x >= "0" && x <= "9";
   endfunction

   always_comb begin
      logic       again;
      logic       go;
      logic [6:0] one, two, k;
      logic [POSITION_BITS-1:0] pos1;
      logic       d0, d1, d2;
      mode_in = mode_ff; pos_in = pos_ff; start_in = start_ff; line_in = line_ff;
      pend_in = pend_ff; halt_in = halt_ff; wlen_in = wlen_ff; dlen_in = dlen_ff;
      dmask_in = dmask_ff; word_in = word_ff;
      tok_count = 2'd0;
      toks = '0;
      pos1 = pos_ff + 1'b1;
      one = K_DOT; two = K_END; k = K_END;
      d0 = 1'b0; d1 = 1'b0; d2 = 1'b0;
      again = 1'b0; go = 1'b0;
      if (step && !halt_ff) begin
         // up to three passes: #mode into line comment, line end, idle rescan
         go = 1'b1;
         for (int p = 0; p < 3; p++) begin
            if (go && !halt_in) begin
               again = 1'b0;
               unique case (mode_in)
                  M_IDLE: begin
                     start_in = pos_ff;
                     k = K_END;
                     if (c == 8'd0) begin
                        toks[tok_count] = '{K_END, E_NONE, 16'(pos_ff), 16'd0, line_in,
                                            1'b0, 1'b1};
                        tok_count = tok_count + 2'd1; halt_in = 1'b1;
                     end else if (c == " " || c == 8'h0d || c == 8'h09) begin
                     end else if (c == 8'h0a) begin
                        if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
                     end else if (alpha(c) || c == "_") begin
                        word_in[7:0] = c; wlen_in = 4'd1; mode_in = M_IDENT;
                     end else if (digit(c)) begin
                        mode_in = M_NUM;
                     end else begin
                        unique case (c)
                           "(": k = K_LPAREN;
                           ")": k = K_RPAREN;
                           "{": k = K_LBRACE;
                           "}": k = K_RBRACE;
                           "[": k = K_LBRACK;
                           "]": k = K_RBRACK;
                           ",": k = K_COMMA;
                           ".": k = K_DOT;
                           ";": k = K_SEMI;
                           ":": k = K_COLON;
                           "+", "-", "*", "/", "%", "&", "|", "!", "=", "<", ">": begin
                              pend_in = c; mode_in = M_OP;
                           end
                           "\"": mode_in = M_STR;
                           "#": begin
                              dlen_in = 5'd1; dmask_in = 3'b111; mode_in = M_DIR;
                           end
                           default: begin
                              toks[tok_count] = '{K_ERR, E_CHAR, 16'(pos_ff), 16'd0,
                                                  line_in, 1'b0, 1'b1};
                              tok_count = tok_count + 2'd1; halt_in = 1'b1;
                           end
                        endcase
                        if (k != K_END) begin
                           toks[tok_count] = '{k, E_NONE, 16'(pos_ff), 16'd1, line_in,
                                               1'b0, 1'b0};
                           tok_count = tok_count + 2'd1;
                        end
                     end
                  end
                  M_IDENT: begin
                     if (alpha(c) || digit(c) || c == "_") begin
                        for (int i = 0; i < KEYWORD_CHARS; i++)
                           if (wlen_ff == 4'(i)) word_in[8*i +: 8] = c;
                        if (wlen_ff <= 4'(KEYWORD_CHARS)) wlen_in = wlen_ff + 4'd1;
                     end else begin
                        toks[tok_count] = '{kw_kind, E_NONE, 16'(start_ff),
                                            16'(pos_ff - start_ff), line_in, 1'b0, 1'b0};
                        tok_count = tok_count + 2'd1; mode_in = M_IDLE; again = 1'b1;
                     end
                  end
                  M_NUM: begin
                     if (digit(c)) begin
                     end else if (c == ".") mode_in = M_NUMDOT;
                     else begin
                        toks[tok_count] = '{K_INT, E_NONE, 16'(start_ff),
                                            16'(pos_ff - start_ff), line_in, 1'b0, 1'b0};
                        tok_count = tok_count + 2'd1; mode_in = M_IDLE; again = 1'b1;
                     end
                  end
                  M_NUMDOT: begin
                     if (digit(c)) mode_in = M_FRAC;
                     else begin
                        toks[0] = '{K_INT, E_NONE, 16'(start_ff),
                                    16'(pos_ff - 1'b1 - start_ff), line_in, 1'b0, 1'b0};
                        toks[1] = '{K_DOT, E_NONE, 16'(pos_ff - 1'b1), 16'd1, line_in,
                                    1'b0, 1'b0};
                        tok_count = 2'd2; mode_in = M_IDLE; again = 1'b1;
                     end
                  end
                  M_FRAC: begin
                     if (!digit(c)) begin
                        toks[tok_count] = '{K_FLOAT, E_NONE, 16'(start_ff),
                                            16'(pos_ff - start_ff), line_in, 1'b0, 1'b0};
                        tok_count = tok_count + 2'd1; mode_in = M_IDLE; again = 1'b1;
                     end
                  end
                  M_STR, M_ESC: begin
                     if (c == 8'd0) begin
                        toks[tok_count] = '{K_ERR, E_STR, 16'(start_ff), 16'd0, line_in,
                                            1'b0, 1'b1};
                        tok_count = tok_count + 2'd1; halt_in = 1'b1; mode_in = M_IDLE;
                     end else if (mode_in == M_ESC) begin
                        if (c == "n" || c == "t" || c == "\\" || c == "\"" || c == "r" ||
                            c == "0") mode_in = M_STR;
                        else begin
                           toks[tok_count] = '{K_ERR, E_ESC, 16'(start_ff), 16'd0,
                                               line_in, 1'b0, 1'b1};
                           tok_count = tok_count + 2'd1; halt_in = 1'b1; mode_in = M_IDLE;
                        end
                     end else if (c == "\"") begin
                        toks[tok_count] = '{K_STRING, E_NONE, 16'(start_ff),
                                            16'(pos1 - start_ff), line_in, 1'b0, 1'b0};
                        tok_count = tok_count + 2'd1; mode_in = M_IDLE;
                     end else if (c == 8'h0a) begin
                        if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
                     end else if (c == "\\") mode_in = M_ESC;
                  end
                  M_LINE: begin
                     if (c == 8'h0a || c == 8'd0) begin
                        mode_in = M_IDLE; again = 1'b1;
                     end
                  end
                  M_BLOCK, M_BSTAR: begin
                     if (c == 8'd0) begin
                        mode_in = M_IDLE; again = 1'b1;
                     end else if (c == "/" && mode_in == M_BSTAR) mode_in = M_IDLE;
                     else begin
                        if (c == 8'h0a && line_in != 16'hFFFF) line_in = line_in + 16'd1;
                        mode_in = (c == "*") ? M_BSTAR : M_BLOCK;
                     end
                  end
                  M_DIR: begin
                     if (alpha(c)) begin
                        if (dlen_ff >= 5'd9 || dir_byte(DIR_AUTOFREE, dlen_ff) != c)
                           dmask_in[0] = 1'b0;
                        if (dlen_ff >= 5'd17 || dir_byte(DIR_LEAKS, dlen_ff) != c)
                           dmask_in[1] = 1'b0;
                        if (dlen_ff >= 5'd5 || dir_byte(DIR_MODE, dlen_ff) != c)
                           dmask_in[2] = 1'b0;
                        if (dlen_ff < 5'd18) dlen_in = dlen_ff + 5'd1;
                     end else begin
                        d0 = dmask_ff[0] && dlen_ff == 5'd9;
                        d1 = dmask_ff[1] && dlen_ff == 5'd17;
                        d2 = dmask_ff[2] && dlen_ff == 5'd5;
                        again = 1'b1;
                        if (d0 || d1) begin
                           toks[tok_count] = '{d0 ? K_AUTOFREE : K_ALLOWLEAKS, E_NONE,
                                               16'(start_ff), 16'(dlen_ff), line_in,
                                               1'b0, 1'b0};
                           tok_count = tok_count + 2'd1; mode_in = M_IDLE;
                        end else if (d2) mode_in = M_LINE;
                        else begin
                           toks[tok_count] = '{K_ERR, E_DIR, 16'(start_ff), 16'd0,
                                               line_in, 1'b0, 1'b1};
                           tok_count = tok_count + 2'd1; halt_in = 1'b1;
                           mode_in = M_IDLE; again = 1'b0;
                        end
                     end
                  end
                  M_OP: begin
                     mode_in = M_IDLE;
                     again = 1'b1;
                     unique case (pend_ff)
                        "+": begin one = K_PLUS;
                           two = (c == "+") ? K_PLUSPLUS : (c == "=") ? K_PLUSEQ : K_END; end
                        "-": begin one = K_MINUS;
                           two = (c == "-") ? K_MINUSMINUS : (c == "=") ? K_MINUSEQ : K_END; end
                        "*": begin one = K_STAR; two = (c == "=") ? K_STAREQ : K_END; end
                        "%": begin one = K_PERCENT; two = (c == "=") ? K_PERCENTEQ : K_END; end
                        "/": begin one = K_SLASH; two = (c == "=") ? K_SLASHEQ : K_END; end
                        "&": begin one = K_AMP; two = (c == "&") ? K_AND : K_END; end
                        "|": begin one = K_END; two = (c == "|") ? K_OR : K_END; end
                        "!": begin one = K_BANG; two = (c == "=") ? K_BANGEQ : K_END; end
                        "=": begin one = K_EQ;
                           two = (c == "=") ? K_EQEQ : (c == ">") ? K_EQGT :
                                 (c == "<") ? K_EQLT : K_END; end
                        "<": begin one = K_LT; two = (c == "=") ? K_LTEQ : K_END; end
                        ">": begin one = K_GT; two = (c == "=") ? K_GTEQ : K_END; end
                        default: begin one = K_END; two = K_END; end
                     endcase
                     if (pend_ff == "/" && c == "/") begin
                        mode_in = M_LINE; again = 1'b0;
                     end else if (pend_ff == "/" && c == "*") begin
                        mode_in = M_BLOCK; again = 1'b0;
                     end else if (pend_ff == "|" && c != "|") begin
                        toks[tok_count] = '{K_ERR, E_BAR, 16'(start_ff), 16'd0, line_in,
                                            1'b0, 1'b1};
                        tok_count = tok_count + 2'd1; halt_in = 1'b1; again = 1'b0;
                     end else if (two != K_END) begin
                        toks[tok_count] = '{two, E_NONE, 16'(start_ff),
                                            16'(pos1 - start_ff), line_in, 1'b0, 1'b0};
                        tok_count = tok_count + 2'd1; again = 1'b0;
                     end else if (one != K_END) begin
                        toks[tok_count] = '{one, E_NONE, 16'(start_ff), 16'd1, line_in,
                                            1'b0, 1'b0};
                        tok_count = tok_count + 2'd1;
                     end
                  end
                  default: begin
                     mode_in = M_IDLE; again = 1'b1;
                  end
               endcase
               go = again;
            end
         end
         for (int t = 0; t < MAX_TOKENS; t++)
            if (tok_count == 2'(t + 1)) toks[t].last = 1'b1;
         pos_in = pos1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; pos_ff <= '0; start_ff <= '0; line_ff <= 16'd1;
         pend_ff <= 8'd0; halt_ff <= 1'b0; wlen_ff <= 4'd0; dlen_ff <= 5'd0;
         dmask_ff <= 3'd0;
      end else begin
         mode_ff <= mode_in; pos_ff <= pos_in; start_ff <= start_in; line_ff <= line_in;
         pend_ff <= pend_in; halt_ff <= halt_in; wlen_ff <= wlen_in; dlen_ff <= dlen_in;
         dmask_ff <= dmask_in;
      end
      word_ff <= word_in;
   end

   assign halted = halt_ff;
endmodule

>>> rtl/core/stok_outq.sv
// ---------------------------------------------------------------------------
// stok_outq
// Small token queue between the scanner and the result channel.
// ---------------------------------------------------------------------------
module stok_outq
   import stok_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_flight,
   input  logic [1:0]                 wr_count,
   input  token_type [MAX_TOKENS-1:0] wr_toks,
   output logic                       room,
   output logic                       out_valid,
   input  logic                       out_ready,
   output token_type                  out_tok
);
   localparam int DEPTH = 8;
   token_type q_ff [DEPTH];
   logic [2:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       pop;

   assign out_valid = cnt_ff != 4'd0;
   assign pop = out_valid && out_ready;
   assign out_tok = q_ff[rd_ff];
   // room for a full burst of three beats, two bursts when a byte is in flight
   assign room = in_flight ? (cnt_ff <= 4'(DEPTH - 2 * MAX_TOKENS))
                           : (cnt_ff <= 4'(DEPTH - MAX_TOKENS));

   always_comb begin
      rd_in = rd_ff + 3'(pop);
      wr_in = wr_ff + 3'(wr_count);
      cnt_in = cnt_ff + 4'(wr_count) - 4'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 3'd0; wr_ff <= 3'd0; cnt_ff <= 4'd0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
      for (int t = 0; t < MAX_TOKENS; t++)
         if (2'(t) < wr_count) q_ff[wr_ff + 3'(t)] <= wr_toks[t];
   end
endmodule

>>> rtl/core/source_tokenizer_top.sv
// ---------------------------------------------------------------------------
// source_tokenizer_top
// Maximal-munch lexical scanner, one source byte per beat.
// ---------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | char_code
// rsp     | out | token fields, last_of_item, ends_source
//
// One byte per cycle is taken while the token queue has room for three beats,
// or for six while a byte still sits in the input register.
// The byte is registered, scanned combinationally, and its tokens (0..3) enter the
// queue, from which rsp takes them in order.
// Reset clears mode, position and the queue and sets the line count to 1; no clearing pass.
// A stalled rsp side backs up the queue and then drops req ready.
// After an end or error token, bytes are taken and dropped.
module source_tokenizer_top
   import stok_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input logic clock,
   input logic reset,
   stok_req_if.sink   req,
   stok_rsp_if.source rsp
);
`include "source_tokenizer_top_defines.svh"

   logic       in_v_ff;
   logic [7:0] in_c_ff;
   logic       room, halted, q_valid;
   logic [1:0] cnt;
   token_type [MAX_TOKENS-1:0] toks;
   token_type  q_tok;

   // queue leaves space for the beat already held in the input register
   assign req.ready = room;

   always_ff @(posedge clock) begin
      if (reset) in_v_ff <= 1'b0;
      else in_v_ff <= req.valid && req.ready;
      in_c_ff <= req.char_code;
   end

   stok_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
      .clock(clock), .reset(reset), .step(in_v_ff), .c(in_c_ff),
      .halted(halted), .tok_count(cnt), .toks(toks));

   stok_outq u_q (
      .clock(clock), .reset(reset), .in_flight(in_v_ff), .wr_count(cnt), .wr_toks(toks),
      .room(room), .out_valid(q_valid), .out_ready(rsp.ready), .out_tok(q_tok));

   assign rsp.valid        = q_valid;
   assign rsp.token_kind   = q_tok.kind;
   assign rsp.error_code   = q_tok.err;
   assign rsp.token_start  = q_tok.start;
   assign rsp.token_length = q_tok.len;
   assign rsp.line_number  = q_tok.line;
   assign rsp.last_of_item = q_tok.last;
   assign rsp.ends_source  = q_tok.ends;

   `ST_ASSERT_NEXT(a_halt_quiet, clock, reset, halted, cnt == 2'd0, "tokens after halt")
   `ST_ASSERT_IMP(a_ends_kind, clock, reset, rsp.valid && rsp.ends_source,
      rsp.token_kind == K_END || rsp.token_kind == K_ERR, "ends on non-final token")
   `ST_ASSERT_IMP(a_err_code, clock, reset, rsp.valid && rsp.token_kind == K_ERR,
      rsp.error_code != E_NONE, "error token without code")
endmodule
